// ===== rtl/crt_pkg.sv =====
// Package for the CSV row tokenizer: result kinds, quote modes, register
// indexes, byte codes and the per-row tokenizer state record.
// No dependencies.
`timescale 1ns / 1ps

package crt_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2,
    KIND_OVFL  = 2'd3
  } crt_kind_e;

  // Quoting modes; the fourth code is never entered.
  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } crt_quote_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DELIMITER = 2'd0;
  localparam logic [1:0] CFG_COLUMNS   = 2'd1;
  localparam logic [1:0] CFG_UTF8      = 2'd2;

  localparam int unsigned CfgDataW = 9;

  // Register reset values.
  localparam logic [7:0] DelimiterReset = 8'd44;
  localparam logic [8:0] ColumnsReset   = 9'd1;

  // Byte codes the tokenizer reacts to.
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;

  // Tokenizer state that is cleared at every row end.
  typedef struct packed {
    crt_quote_e  quote_mode;
    logic        escape_pending;
    logic        close_pending;
    logic [1:0]  utf8_left;
    logic        row_has_bytes;
    logic        overflow_seen;
  } crt_state_t;

  localparam crt_state_t StateClear = '{
    quote_mode:     QUOTE_NONE,
    escape_pending: 1'b0,
    close_pending:  1'b0,
    utf8_left:      2'd0,
    row_has_bytes:  1'b0,
    overflow_seen:  1'b0
  };

  // One decoded result of a step.
  typedef struct packed {
    logic        emit;
    crt_kind_e   kind;
    logic [7:0]  out_byte;
  } crt_res_t;

endpackage

// ===== rtl/crt_if.sv =====
// Handshake channels of the CSV row tokenizer: byte input and token output.
// Each carries valid, ready and the payload. No dependencies.
`timescale 1ns / 1ps

interface crt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, in_byte, end_of_stream, input ready);
  modport sink   (input valid, in_byte, end_of_stream, output ready);
endinterface

interface crt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [7:0]  column_index;
  logic [31:0] row_index;

  modport source (output valid, kind, out_byte, column_index, row_index, input ready);
  modport sink   (input valid, kind, out_byte, column_index, row_index, output ready);
endinterface

// ===== rtl/csv_row_tokenizer.sv =====
// CSV row tokenizer top level: input register, tokenizer step, result
// register and configuration registers. Depends on crt_pkg, crt_if, crt_step.
//
// Channel   Dir  Payload                                   Accepted when
// in_i      in   in_byte[7:0], end_of_stream               valid && ready
// out_o     out  kind[1:0], out_byte[7:0], column_index[7:0],
//                row_index[31:0]                           valid && ready
// cfg       in   cfg_idx_i[1:0], cfg_data_i[8:0]           cfg_we_i
//
// One item per cycle unless the output stalls; an item waits in the input
// register, then its token enters the result register. The state step is
// combinational, so back-to-back bytes see each other's effect with no bubble.
// Reset clears the state, the row counter and all valid flags, and loads
// the register defaults. When the result register is full and not taken,
// the item in the input register waits and input ready follows out ready.
`timescale 1ns / 1ps

module csv_row_tokenizer #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [crt_pkg::CfgDataW-1:0]  cfg_data_i,
  crt_in_if.sink                        in_i,
  crt_out_if.source                     out_o
);

  localparam int unsigned ColW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  // Configuration registers.
  logic [7:0] delimiter_q;
  logic [8:0] columns_q;
  logic       utf8_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q <= crt_pkg::DelimiterReset;
      columns_q   <= crt_pkg::ColumnsReset;
      utf8_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crt_pkg::CFG_DELIMITER: delimiter_q <= cfg_data_i[7:0];
        crt_pkg::CFG_COLUMNS:   columns_q   <= cfg_data_i;
        crt_pkg::CFG_UTF8:      utf8_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic       s0_valid_q;
  logic [7:0] s0_byte_q;
  logic       s0_eos_q;
  logic       fire;
  logic       out_valid_q;

  assign fire       = s0_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s0_byte_q <= in_i.in_byte;
      s0_eos_q  <= in_i.end_of_stream;
    end
  end

  // Tokenizer state and the step logic.
  crt_pkg::crt_state_t st_q, st_d;
  logic [ColW-1:0]     col_q, col_d;
  logic [31:0]         row_q;
  logic                row_inc;
  crt_pkg::crt_res_t   res;

  crt_step #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .ColW        (ColW)
  ) u_step (
    .st_i        (st_q),
    .col_i       (col_q),
    .delimiter_i (delimiter_q),
    .columns_i   (columns_q),
    .utf8_mode_i (utf8_mode_q),
    .in_byte_i   (s0_byte_q),
    .eos_i       (s0_eos_q),
    .st_o        (st_d),
    .col_o       (col_d),
    .row_inc_o   (row_inc),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= crt_pkg::StateClear;
      col_q <= '0;
      row_q <= '0;
    end else if (fire) begin
      st_q  <= st_d;
      col_q <= col_d;
      if (row_inc) row_q <= row_q + 32'd1;
    end
  end

  // Result register.
  crt_pkg::crt_kind_e out_kind_q;
  logic [7:0]         out_byte_q;
  logic [7:0]         out_col_q;
  logic [31:0]        out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= res.emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.emit) begin
      out_kind_q <= res.kind;
      out_byte_q <= res.out_byte;
      out_col_q  <= 8'(col_q);
      out_row_q  <= row_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_kind_q;
  assign out_o.out_byte     = out_byte_q;
  assign out_o.column_index = out_col_q;
  assign out_o.row_index    = out_row_q;

  // A pending quote close only exists inside a quoted span.
  a_close_in_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.close_pending |-> st_q.quote_mode != crt_pkg::QUOTE_NONE)
    else $error("close pending outside quotes");

  // The overflow error is given once per row.
  a_ovfl_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.emit && res.kind == crt_pkg::KIND_OVFL) |-> !st_q.overflow_seen)
    else $error("second overflow in one row");

  // The row counter advances exactly with an emitted row end.
  a_row_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !(res.emit && res.kind == crt_pkg::KIND_ROW)) |=> row_q == $past(row_q))
    else $error("row counter moved without a row end");

  // A stalled item in the input register is held.
  a_s0_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && !fire) |=> (s0_valid_q && $stable(s0_byte_q) && $stable(s0_eos_q)))
    else $error("stalled input item lost");

endmodule

// ===== rtl/crt_step.sv =====
// Next-state and result logic of the CSV row tokenizer for one item.
// Purely combinational. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_step #(
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned ColW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
  input  crt_pkg::crt_state_t st_i,
  input  logic [ColW-1:0]     col_i,
  input  logic [7:0]          delimiter_i,
  input  logic [8:0]          columns_i,
  input  logic                utf8_mode_i,
  input  logic [7:0]          in_byte_i,
  input  logic                eos_i,
  output crt_pkg::crt_state_t st_o,
  output logic [ColW-1:0]     col_o,
  output logic                row_inc_o,
  output crt_pkg::crt_res_t   res_o
);

  localparam int unsigned LimW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CmpW = (LimW > 9) ? LimW : 9;
  localparam logic [CmpW-1:0] MaxLimit = CmpW'(MAX_COLUMNS);

  logic [CmpW-1:0]     cols_ext;
  logic [CmpW-1:0]     limit;
  logic [CmpW-1:0]     col_p1;
  crt_pkg::crt_quote_e qm;
  crt_pkg::crt_quote_e qmode;
  logic                esc;
  logic                go;
  logic                is_data;
  logic [7:0]          data_b;
  logic                is_row_end;
  crt_pkg::crt_state_t st_mid;
  logic [ColW-1:0]     col_mid;
  crt_pkg::crt_res_t   res_mid;

  // Column limit clipped to what the column counter can hold.
  assign cols_ext = CmpW'(columns_i);
  assign limit    = (cols_ext > MaxLimit) ? MaxLimit : cols_ext;
  assign col_p1   = CmpW'(col_i) + CmpW'(1);
  assign esc      = st_i.escape_pending;
  assign qmode    = (in_byte_i == crt_pkg::ChSq) ? crt_pkg::QUOTE_SINGLE
                                                 : crt_pkg::QUOTE_DOUBLE;

  // Classify the byte: data, row end, field end, overflow or dropped.
  always_comb begin
    st_mid     = st_i;
    col_mid    = col_i;
    res_mid    = '{emit: 1'b0, kind: crt_pkg::KIND_DATA, out_byte: 8'd0};
    is_data    = 1'b0;
    data_b     = in_byte_i;
    is_row_end = 1'b0;
    qm         = st_i.quote_mode;
    go         = 1'b0;

    if (eos_i) begin
      if (st_i.row_has_bytes || st_i.overflow_seen) begin
        is_row_end = 1'b1;
      end else begin
        st_mid = crt_pkg::StateClear;
        col_mid = '0;
      end
    end else if (st_i.utf8_left != 2'd0) begin
      st_mid.utf8_left = st_i.utf8_left - 2'd1;
      is_data = 1'b1;
    end else if (st_i.close_pending) begin
      st_mid.close_pending = 1'b0;
      if ((st_i.quote_mode == crt_pkg::QUOTE_SINGLE && in_byte_i == crt_pkg::ChSq) ||
          (st_i.quote_mode == crt_pkg::QUOTE_DOUBLE && in_byte_i == crt_pkg::ChDq)) begin
        is_data = 1'b1;
      end else begin
        qm = crt_pkg::QUOTE_NONE;
        go = 1'b1;
      end
    end else begin
      go = 1'b1;
    end

    if (go) begin
      st_mid.quote_mode = qm;
      unique case (in_byte_i)
        crt_pkg::ChLf: begin
          if (qm == crt_pkg::QUOTE_NONE) is_row_end = 1'b1;
          else is_data = 1'b1;
        end
        crt_pkg::ChCr: begin
          if (qm != crt_pkg::QUOTE_NONE) is_data = 1'b1;
        end
        crt_pkg::ChBsl: begin
          if (esc) is_data = 1'b1;
          else st_mid.escape_pending = 1'b1;
        end
        crt_pkg::ChSpace: begin
          if (esc || qm != crt_pkg::QUOTE_NONE) is_data = 1'b1;
        end
        crt_pkg::ChSq, crt_pkg::ChDq: begin
          if (esc || (qm != crt_pkg::QUOTE_NONE && qm != qmode)) begin
            is_data = 1'b1;
          end else if (qm == crt_pkg::QUOTE_NONE) begin
            st_mid.quote_mode = qmode;
          end else begin
            st_mid.close_pending = 1'b1;
          end
        end
        crt_pkg::ChN: begin
          is_data = 1'b1;
          if (esc) data_b = crt_pkg::ChLf;
        end
        crt_pkg::ChR: begin
          is_data = 1'b1;
          if (esc) data_b = crt_pkg::ChCr;
        end
        crt_pkg::ChT: begin
          is_data = 1'b1;
          if (esc) data_b = crt_pkg::ChTab;
        end
        default: begin
          if (utf8_mode_i && in_byte_i[7]) begin
            // Lead byte: two continuation bytes when bit 5 is set, else one.
            st_mid.utf8_left = in_byte_i[5] ? 2'd2 : 2'd1;
            is_data = 1'b1;
          end else if (qm == crt_pkg::QUOTE_NONE && in_byte_i == delimiter_i) begin
            st_mid.escape_pending = 1'b0;
            st_mid.row_has_bytes  = 1'b1;
            if (!st_i.overflow_seen) begin
              res_mid.emit = 1'b1;
              if (col_p1 >= limit) begin
                st_mid.overflow_seen = 1'b1;
                res_mid.kind = crt_pkg::KIND_OVFL;
              end else begin
                res_mid.kind = crt_pkg::KIND_FIELD;
                col_mid = col_i + ColW'(1);
              end
            end
          end else begin
            is_data = 1'b1;
          end
        end
      endcase
    end
  end

  // Apply the data or row-end outcome on top of the classified state.
  always_comb begin
    st_o      = st_mid;
    col_o     = col_mid;
    res_o     = res_mid;
    row_inc_o = 1'b0;
    if (is_row_end) begin
      st_o      = crt_pkg::StateClear;
      col_o     = '0;
      row_inc_o = 1'b1;
      res_o     = '{emit: 1'b1, kind: crt_pkg::KIND_ROW, out_byte: 8'd0};
    end else if (is_data) begin
      st_o.row_has_bytes  = 1'b1;
      st_o.escape_pending = 1'b0;
      res_o = '{emit: !st_i.overflow_seen, kind: crt_pkg::KIND_DATA, out_byte: data_b};
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the CSV row tokenizer: directed and random byte streams,
// with a local prediction of every token. Depends on crt_pkg, crt_if and
// csv_row_tokenizer.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned MaxColumns   = 256;
  localparam int unsigned RandomItems  = 2000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned StallLimit   = 3000;

  // One token as the block reports it.
  typedef struct packed {
    crt_pkg::crt_kind_e kind;
    logic [7:0]         out_byte;
    logic [7:0]         column_index;
    logic [31:0]        row_index;
  } token_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [crt_pkg::CfgDataW-1:0] cfg_data;

  crt_in_if  in_if ();
  crt_out_if out_if ();

  csv_row_tokenizer #(
    .MAX_COLUMNS (MaxColumns)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Register copies, loaded with the reset values.
  logic [7:0]  cfg_delim = crt_pkg::DelimiterReset;
  logic [8:0]  cfg_cols  = crt_pkg::ColumnsReset;
  logic        cfg_utf8  = 1'b0;

  // Tokenizer state of the prediction.
  logic [1:0]  tk_quote     = crt_pkg::QUOTE_NONE;
  logic        tk_escape    = 1'b0;
  logic        tk_close     = 1'b0;
  logic [1:0]  tk_utf8_left = 2'd0;
  int unsigned tk_column    = 0;
  logic        tk_row_bytes = 1'b0;
  logic [31:0] tk_rows      = '0;
  logic        tk_overflow  = 1'b0;

  token_t pending_tokens[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned items_in      = 0;
  int unsigned tokens_checked = 0;
  int unsigned rows_seen     = 0;
  int unsigned overflows_seen = 0;
  int unsigned mismatches    = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_row_state();
    tk_quote     = crt_pkg::QUOTE_NONE;
    tk_escape    = 1'b0;
    tk_close     = 1'b0;
    tk_utf8_left = 2'd0;
    tk_column    = 0;
    tk_row_bytes = 1'b0;
    tk_overflow  = 1'b0;
  endfunction

  function automatic token_t make_token(crt_pkg::crt_kind_e kind, logic [7:0] value);
    token_t tok;
    tok.kind         = kind;
    tok.out_byte     = value;
    tok.column_index = tk_column[7:0];
    tok.row_index    = tk_rows;
    return tok;
  endfunction

  // A data byte marks the row as used; it is hidden once the row overflowed.
  function automatic bit emit_data(input logic [7:0] value, output token_t tok);
    tk_row_bytes = 1'b1;
    tk_escape    = 1'b0;
    tok = make_token(crt_pkg::KIND_DATA, value);
    return !tk_overflow;
  endfunction

  function automatic bit finish_row(output token_t tok);
    tok = make_token(crt_pkg::KIND_ROW, 8'h00);
    tk_rows = tk_rows + 32'd1;
    clear_row_state();
    return 1'b1;
  endfunction

  // Opening quote, closing candidate, or a plain quote byte.
  function automatic bit quote_char(input logic [7:0] value, input logic [1:0] mode,
                                    input logic escaped, output token_t tok);
    tok = '0;
    if (escaped || (tk_quote != crt_pkg::QUOTE_NONE && tk_quote != mode)) begin
      return emit_data(value, tok);
    end
    if (tk_quote == crt_pkg::QUOTE_NONE) begin
      tk_quote = mode;
    end else begin
      tk_close = 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the token caused by one input item, if any.
  function automatic bit tokenize_byte(input logic [7:0] b, input logic eos,
                                       output token_t tok);
    logic        escaped;
    int unsigned limit;
    tok = '0;
    if (eos) begin
      if (tk_row_bytes || tk_overflow) begin
        return finish_row(tok);
      end
      clear_row_state();
      return 1'b0;
    end
    if (tk_utf8_left != 2'd0) begin
      tk_utf8_left = tk_utf8_left - 2'd1;
      return emit_data(b, tok);
    end
    // A matching quote after a closing candidate is a literal; anything else closes.
    if (tk_close) begin
      tk_close = 1'b0;
      if ((tk_quote == crt_pkg::QUOTE_SINGLE && b == crt_pkg::ChSq) ||
          (tk_quote == crt_pkg::QUOTE_DOUBLE && b == crt_pkg::ChDq)) begin
        return emit_data(b, tok);
      end
      tk_quote = crt_pkg::QUOTE_NONE;
    end
    escaped = tk_escape;
    case (b)
      crt_pkg::ChLf: begin
        if (tk_quote == crt_pkg::QUOTE_NONE) return finish_row(tok);
        return emit_data(b, tok);
      end
      crt_pkg::ChCr: begin
        if (tk_quote == crt_pkg::QUOTE_NONE) return 1'b0;
        return emit_data(b, tok);
      end
      crt_pkg::ChBsl: begin
        if (escaped) return emit_data(b, tok);
        tk_escape = 1'b1;
        return 1'b0;
      end
      crt_pkg::ChSpace: begin
        if (!escaped && tk_quote == crt_pkg::QUOTE_NONE) return 1'b0;
        return emit_data(b, tok);
      end
      crt_pkg::ChSq: return quote_char(b, crt_pkg::QUOTE_SINGLE, escaped, tok);
      crt_pkg::ChDq: return quote_char(b, crt_pkg::QUOTE_DOUBLE, escaped, tok);
      crt_pkg::ChN:  return emit_data(escaped ? crt_pkg::ChLf : b, tok);
      crt_pkg::ChR:  return emit_data(escaped ? crt_pkg::ChCr : b, tok);
      crt_pkg::ChT:  return emit_data(escaped ? crt_pkg::ChTab : b, tok);
      default: ;
    endcase
    // Lead byte of a multibyte sequence: one or two continuation bytes follow.
    if (cfg_utf8 && b[7]) begin
      tk_utf8_left = b[5] ? 2'd2 : 2'd1;
      return emit_data(b, tok);
    end
    if (tk_quote == crt_pkg::QUOTE_NONE && b == cfg_delim) begin
      tk_escape    = 1'b0;
      tk_row_bytes = 1'b1;
      if (tk_overflow) return 1'b0;
      limit = (cfg_cols > MaxColumns) ? MaxColumns : cfg_cols;
      if (tk_column + 1 >= limit) begin
        tk_overflow = 1'b1;
        tok = make_token(crt_pkg::KIND_OVFL, 8'h00);
        return 1'b1;
      end
      tok = make_token(crt_pkg::KIND_FIELD, 8'h00);
      tk_column = tk_column + 1;
      return 1'b1;
    end
    return emit_data(b, tok);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one item after a random gap and predicts its token on acceptance.
  task automatic send_item(input logic [7:0] b, input logic eos);
    token_t tok;
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.in_byte       <= b;
    in_if.end_of_stream <= eos;
    do @(posedge clk); while (!in_if.ready);
    items_in++;
    if (tokenize_byte(b, eos, tok)) begin
      pending_tokens.push_back(tok);
    end
  endtask

  // Lowers valid and waits until every predicted token has come out.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      crt_pkg::CFG_DELIMITER: cfg_delim = data[7:0];
      crt_pkg::CFG_COLUMNS:   cfg_cols  = data;
      crt_pkg::CFG_UTF8:      cfg_utf8  = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] delim, input logic [8:0] cols,
                           input logic utf8);
    write_reg(crt_pkg::CFG_DELIMITER, {1'b0, delim});
    write_reg(crt_pkg::CFG_COLUMNS, cols);
    write_reg(crt_pkg::CFG_UTF8, {8'd0, utf8});
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] text_byte();
    case ($urandom_range(11, 0))
      0:       return crt_pkg::ChSpace;
      1:       return crt_pkg::ChCr;
      2:       return crt_pkg::ChN;
      3:       return crt_pkg::ChR;
      4:       return crt_pkg::ChT;
      5:       return crt_pkg::ChTab;
      default: return 8'($urandom_range(8'h7A, 8'h30));
    endcase
  endfunction

  // One field: plain text, a quoted span, escape pairs or multibyte sequences.
  task automatic send_field(input int unsigned len);
    logic [7:0] q;
    logic [7:0] lead;
    case ($urandom_range(3, 0))
      0: repeat (len) send_item(text_byte(), 1'b0);
      1: begin
        q = $urandom_range(1, 0) ? crt_pkg::ChDq : crt_pkg::ChSq;
        send_item(q, 1'b0);
        repeat (len) begin
          case ($urandom_range(7, 0))
            0: begin
              send_item(q, 1'b0);
              send_item(q, 1'b0);
            end
            1:       send_item(cfg_delim, 1'b0);
            2:       send_item(crt_pkg::ChLf, 1'b0);
            3:       send_item(($urandom_range(1, 0) ? crt_pkg::ChDq : crt_pkg::ChSq), 1'b0);
            default: send_item(text_byte(), 1'b0);
          endcase
        end
        send_item(q, 1'b0);
      end
      2: repeat (len) begin
        send_item(crt_pkg::ChBsl, 1'b0);
        case ($urandom_range(4, 0))
          0:       send_item(cfg_delim, 1'b0);
          1:       send_item(crt_pkg::ChBsl, 1'b0);
          2:       send_item(crt_pkg::ChDq, 1'b0);
          default: send_item(text_byte(), 1'b0);
        endcase
      end
      default: repeat (len) begin
        lead = 8'h80 | 8'($urandom_range(127, 0));
        send_item(lead, 1'b0);
        repeat (lead[5] ? 2 : 1) send_item(8'($urandom_range(255, 0)), 1'b0);
      end
    endcase
  endtask

  // A well-formed row, usually ended by LF, sometimes by CR LF or stream end.
  task automatic send_row();
    int unsigned n_fields;
    n_fields = ($urandom_range(7, 0) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
    for (int unsigned f = 0; f < n_fields; f++) begin
      if (f != 0) send_item(cfg_delim, 1'b0);
      send_field($urandom_range(5, 0));
    end
    case ($urandom_range(9, 0))
      0: send_item(8'($urandom_range(255, 0)), 1'b1);
      1: begin
        send_item(crt_pkg::ChCr, 1'b0);
        send_item(crt_pkg::ChLf, 1'b0);
      end
      default: send_item(crt_pkg::ChLf, 1'b0);
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(8, 1)) begin
      send_item(8'($urandom_range(255, 0)), ($urandom_range(15, 0) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: dropped bytes, escapes, doubled quotes, overflow at one column.
  task automatic test_reset_defaults();
    logic [7:0] seq [18] = '{8'h00, crt_pkg::ChSpace, crt_pkg::ChCr, crt_pkg::ChBsl,
                             crt_pkg::ChN, crt_pkg::ChBsl, crt_pkg::ChCr, crt_pkg::ChT,
                             crt_pkg::ChDq, "x", crt_pkg::ChDq, crt_pkg::ChDq,
                             crt_pkg::ChDq, crt_pkg::DelimiterReset,
                             crt_pkg::ChSq, crt_pkg::ChDq, crt_pkg::ChSq, crt_pkg::ChLf};
    send_idle_pct = 38;
    recv_idle_pct = 78;
    // Stream end on an empty row gives nothing.
    send_item(8'hFF, 1'b1);
    foreach (seq[i]) send_item(seq[i], 1'b0);
    drain();
  endtask

  // Escaped delimiter, a line feed inside quotes, multibyte pass-through and
  // stream end while an escape is open.
  task automatic test_escape_overflow_utf8();
    logic [7:0] seq [14] = '{crt_pkg::ChBsl, crt_pkg::DelimiterReset,
                             crt_pkg::DelimiterReset, "q", crt_pkg::ChDq, crt_pkg::ChLf,
                             crt_pkg::ChDq, crt_pkg::ChLf, 8'hE3, crt_pkg::ChLf,
                             crt_pkg::DelimiterReset, 8'hC5, 8'hFF, crt_pkg::ChBsl};
    configure(crt_pkg::DelimiterReset, 9'd2, 1'b1);
    foreach (seq[i]) send_item(seq[i], 1'b0);
    send_item(8'h00, 1'b1);
    drain();
  endtask

  // With a column limit of zero the first unquoted delimiter of a row overflows.
  task automatic test_zero_column_limit();
    configure(crt_pkg::DelimiterReset, 9'd0, 1'b0);
    send_item(crt_pkg::DelimiterReset, 1'b0);
    send_item("a", 1'b0);
    send_item(crt_pkg::ChLf, 1'b0);
    drain();
  endtask

  // Random rows and noise under six settings and three idling patterns.
  task automatic test_random_traffic();
    int unsigned target;
    for (int k = 0; k < 6; k++) begin
      send_idle_pct = (k < 2) ? 38 : (k < 4) ? 78 : 0;
      recv_idle_pct = (k < 2) ? 78 : (k < 4) ? 38 : 0;
      case (k)
        0:       configure(crt_pkg::DelimiterReset, 9'd4, 1'b1);
        1:       configure(8'h3B, 9'd511, 1'b0);
        2:       configure(8'h00, 9'd1, 1'b1);
        3:       configure(8'hFF, 9'd256, 1'b0);
        4:       configure(crt_pkg::ChTab, 9'd3, 1'b1);
        default: configure(8'($urandom_range(255, 0)), 9'($urandom_range(8, 0)),
                           1'($urandom_range(1, 0)));
      endcase
      target = items_in + RandomItems / 6;
      while (items_in < target) begin
        if ($urandom_range(9, 0) < 2) send_noise();
        else send_row();
      end
      drain();
    end
  endtask

  // The receiver holds off for a long stretch while rows keep coming.
  task automatic test_receiver_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_req = HoldCycles;
    repeat (8) send_row();
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // Each accepted token is compared with the oldest prediction.
  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        $display("%0t: token with none expected, kind %0d byte 0x%0h", $time,
                 out_if.kind, out_if.out_byte);
      end else begin
        want = pending_tokens.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_if.kind));
        check_field("out_byte", 32'(want.out_byte), 32'(out_if.out_byte));
        check_field("column_index", 32'(want.column_index), 32'(out_if.column_index));
        check_field("row_index", want.row_index, out_if.row_index);
        tokens_checked++;
        if (out_if.kind == crt_pkg::KIND_ROW) rows_seen++;
        if (out_if.kind == crt_pkg::KIND_OVFL) overflows_seen++;
      end
    end
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no item moved for %0d cycles, %0d tokens outstanding", $time,
               idle_cycles, pending_tokens.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid         = 1'b0;
    in_if.in_byte       = 8'h00;
    in_if.end_of_stream = 1'b0;
    out_if.ready        = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = crt_pkg::CFG_DELIMITER;
    cfg_data            = '0;
    rst_n               = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_escape_overflow_utf8();
    test_zero_column_limit();
    test_random_traffic();
    test_receiver_stall();
    drain();

    $display("Sent %0d items, checked %0d tokens: %0d row ends, %0d column overflows.",
             items_in, tokens_checked, rows_seen, overflows_seen);
    $display("Covered quoting, escapes, multibyte pass-through and long output stalls.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== csv_row_tokenizer.f =====
rtl/crt_pkg.sv
rtl/crt_if.sv
rtl/crt_step.sv
rtl/csv_row_tokenizer.sv
verif/tb_top.sv
